// ----- hdl/glzw_pkg.sv -----
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared constants, types and helpers for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int TABLE_SIZE     = 4096;
    localparam int ADDR_W         = 12;
    localparam int BUF_W          = 20;
    localparam int BCNT_W         = 5;
    localparam int CW_W           = 4;
    localparam int NFC_W          = 13;
    localparam int BLEN_W         = 13;
    localparam int PCNT_W         = 7;
    localparam int MAX_PIXELS     = 64;
    localparam int PIX_IDX_W      = 6;
    localparam int MCS_W          = 4;
    localparam int CFG_W          = 32;
    localparam int TDATA_W        = 520;
    localparam int DEF_PIXELS_PER_RESULT = 64;
    localparam logic [MCS_W-1:0] MCS_RESET = 4'd8;

    // first byte of each entry travels in a register beside the walk,
    // so the table holds only prefix and suffix
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [7:0]        suffix;
    } dict_entry_t;

    typedef enum logic [1:0] {
        COND_RUN      = 2'd0,
        COND_OK       = 2'd1,
        COND_BADCOUNT = 2'd2,
        COND_ILLEGAL  = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CODE, ST_ISSUE, ST_WALK, ST_ROOT, ST_POP, ST_END
    } state_t;

    typedef enum logic {
        REG_MIN_CODE_SIZE   = 1'b0,
        REG_EXPECTED_PIXELS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic       push;
        logic [7:0] pixel;
        logic       fin;
        cond_t      cond;
    } pack_ctl_t;

    typedef struct packed {
        logic ready;
        logic busy;
    } pack_sts_t;

    // clamp the minimum code size to 2..8
    function automatic logic [CW_W-1:0] eff_size(input logic [MCS_W-1:0] m);
        logic [CW_W-1:0] r;
        r = m;
        if (m < 4'd2) r = 4'd2;
        if (m > 4'd8) r = 4'd8;
        return r;
    endfunction

endpackage

// ----- hdl/gif_lzw_decoder.sv -----
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF LZW raster decoder: code bytes in, packed pixel indices out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one code-stream byte per item (sub-block length bytes already
//   stripped). m_ channel: up to PIXELS_PER_RESULT pixel bytes per item;
//   tlast marks the final item caused by one input byte, tuser carries the
//   condition (running, end ok, end with wrong count, illegal code).
//   A byte is taken only when the decoder is idle. Each byte passes through
//   the take, the code step that stops the byte and the result step; each
//   code it completes adds a code step, an issue step, a walk with n-1 table
//   reads for a string of n pixels, a root step and the pop loop, and each
//   clear code adds a code step. A full result is sent before decoding goes
//   on. The table and the stack are synchronous memories with one read and
//   one write port, so the walk moves one pixel a cycle, the pop when not held.
//   Reset (aresetn low, synchronous) restarts decoding as after a clear
//   code with minimum code size 8; a min_code_size write does so with its size.
//   When the receiver stalls, the held result stays on m_ and decoding
//   stops at the next pixel that needs room; nothing is dropped.
//   After end of information or an illegal code, bytes are taken and
//   ignored until the next min_code_size write or reset.
// ----------------------------------------------------------------------------
module gif_lzw_decoder
    import glzw_pkg::*;
#(
    parameter int PIXELS_PER_RESULT = DEF_PIXELS_PER_RESULT
)
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // input bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [511:0] pixels_0_7..pixels_56_63,
                                          // [518:512] pixel_count, [519] zero
    output logic               m_tlast,
    output logic [1:0]         m_tuser    // [1:0] condition
);

    // control state
    state_t             state_reg, state_next;
    logic [MCS_W-1:0]   mcs_reg, mcs_next;
    logic [CFG_W-1:0]   expected_reg, expected_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [BCNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [CW_W-1:0]    width_reg, width_next;
    logic [NFC_W-1:0]   nfc_reg, nfc_next;
    logic [ADDR_W-1:0]  prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [7:0]         prev_first_reg, prev_first_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [ADDR_W-1:0]  c_reg, c_next;
    logic               add_pend_reg, add_pend_next;
    logic [31:0]        emitted_reg, emitted_next;
    logic               finished_reg, finished_next;
    logic               failed_reg, failed_next;
    cond_t              cond_reg, cond_next;
    logic [NFC_W-1:0]   sp_reg, sp_next;
    logic               pend_reg, pend_next;
    logic [BLEN_W-1:0]  blen_reg, blen_next;

    // memory ports
    logic               dict_we, dict_re;
    logic [ADDR_W-1:0]  dict_raddr;
    dict_entry_t        dict_wdata, dict_rdata;
    logic               stk_we, stk_re;
    logic [7:0]         stk_wdata, stk_rdata;
    pack_ctl_t          pk_ctl;
    pack_sts_t          pk_sts;

    // decode helpers
    logic [CW_W-1:0]    m_eff;
    logic [NFC_W-1:0]   clr;
    logic [NFC_W-1:0]   wmask;
    logic               have_code;
    logic [ADDR_W-1:0]  code;
    logic               is_end, is_clr, is_lt, is_nfc;
    logic               c_is_str, pfx_is_str;
    logic               do_add;
    logic [7:0]         add_suffix;
    logic [NFC_W-1:0]   nfc_inc;
    logic               blen_full, take, issue, pop_done, fin_needed;

    assign m_eff      = eff_size(mcs_reg);
    assign clr        = NFC_W'(1) << m_eff;
    assign wmask      = (NFC_W'(1) << width_reg) - NFC_W'(1);
    assign have_code  = bcnt_reg >= BCNT_W'(width_reg);
    assign code       = buf_reg[ADDR_W-1:0] & wmask[ADDR_W-1:0];
    assign is_end     = {1'b0, code} == clr + NFC_W'(1);
    assign is_clr     = {1'b0, code} == clr;
    assign is_lt      = {1'b0, code} < nfc_reg;
    assign is_nfc     = ({1'b0, code} == nfc_reg) && prev_valid_reg;
    assign c_is_str   = {1'b0, c_reg} >= clr;
    assign pfx_is_str = {1'b0, dict_rdata.prefix} >= clr;
    assign nfc_inc    = nfc_reg + NFC_W'(1);
    assign blen_full  = blen_reg == BLEN_W'(TABLE_SIZE);
    assign take       = pend_reg && (blen_full || pk_sts.ready);
    assign issue      = (!pend_reg || take) && (sp_reg != '0);
    assign pop_done   = (sp_reg == '0) && !pend_reg;
    assign fin_needed = (blen_reg != '0) || (cond_reg != COND_RUN);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !finished_reg && !failed_reg) state_next = ST_CODE;
            end
            ST_CODE: begin
                if (!have_code)                 state_next = ST_END;
                else if (is_end)                state_next = ST_END;
                else if (is_clr)                state_next = ST_CODE;
                else if (is_lt || is_nfc)       state_next = ST_ISSUE;
                else                            state_next = ST_END;
            end
            ST_ISSUE: begin
                state_next = c_is_str ? ST_WALK : ST_ROOT;
            end
            ST_WALK: begin
                if (!pfx_is_str) state_next = ST_ROOT;
            end
            ST_ROOT: state_next = ST_POP;
            ST_POP: begin
                if (pop_done) state_next = ST_CODE;
            end
            ST_END: begin
                if (!fin_needed || !pk_sts.busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mcs_next        = mcs_reg;
        expected_next   = expected_reg;
        buf_next        = buf_reg;
        bcnt_next       = bcnt_reg;
        width_next      = width_reg;
        nfc_next        = nfc_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        prev_first_next = prev_first_reg;
        cur_next        = cur_reg;
        c_next          = c_reg;
        add_pend_next   = add_pend_reg;
        emitted_next    = emitted_reg;
        finished_next   = finished_reg;
        failed_next     = failed_reg;
        cond_next       = cond_reg;
        sp_next         = sp_reg;
        pend_next       = pend_reg;
        blen_next       = blen_reg;
        s_tready        = 1'b0;
        do_add          = 1'b0;
        add_suffix      = prev_first_reg;
        dict_re         = 1'b0;
        dict_raddr      = c_reg;
        stk_we          = 1'b0;
        stk_wdata       = dict_rdata.suffix;
        stk_re          = 1'b0;
        pk_ctl.push     = 1'b0;
        pk_ctl.pixel    = stk_rdata;
        pk_ctl.fin      = 1'b0;
        pk_ctl.cond     = cond_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && !finished_reg && !failed_reg) begin
                    buf_next  = buf_reg | (BUF_W'(s_tdata) << bcnt_reg);
                    bcnt_next = bcnt_reg + BCNT_W'(8);
                    blen_next = '0;
                    cond_next = COND_RUN;
                end
            end
            ST_CODE: begin
                if (have_code) begin
                    buf_next  = buf_reg >> width_reg;
                    bcnt_next = bcnt_reg - BCNT_W'(width_reg);
                    if (is_end) begin
                        finished_next = 1'b1;
                        cond_next = (emitted_reg == expected_reg) ? COND_OK : COND_BADCOUNT;
                    end else if (is_clr) begin
                        width_next      = m_eff + CW_W'(1);
                        nfc_next        = clr + NFC_W'(2);
                        prev_valid_next = 1'b0;
                    end else if (is_lt) begin
                        cur_next      = code;
                        c_next        = code;
                        add_pend_next = prev_valid_reg;
                    end else if (is_nfc) begin
                        // entry is previous string plus its own first byte
                        do_add        = 1'b1;
                        add_suffix    = prev_first_reg;
                        cur_next      = code;
                        c_next        = code;
                        add_pend_next = 1'b0;
                    end else begin
                        failed_next = 1'b1;
                        cond_next   = COND_ILLEGAL;
                    end
                end
            end
            ST_ISSUE: begin
                dict_re    = c_is_str;
                dict_raddr = c_reg;
            end
            ST_WALK: begin
                stk_we       = 1'b1;
                stk_wdata    = dict_rdata.suffix;
                sp_next      = sp_reg + NFC_W'(1);
                emitted_next = emitted_reg + 32'd1;
                c_next       = dict_rdata.prefix;
                dict_re      = pfx_is_str;
                dict_raddr   = dict_rdata.prefix;
            end
            ST_ROOT: begin
                stk_we          = 1'b1;
                stk_wdata       = c_reg[7:0];
                sp_next         = sp_reg + NFC_W'(1);
                emitted_next    = emitted_reg + 32'd1;
                do_add          = add_pend_reg;
                add_suffix      = c_reg[7:0];
                prev_next       = cur_reg;
                prev_valid_next = 1'b1;
                prev_first_next = c_reg[7:0];
            end
            ST_POP: begin
                pk_ctl.push  = pend_reg && !blen_full;
                pk_ctl.pixel = stk_rdata;
                stk_re       = issue;
                if (issue) begin
                    sp_next   = sp_reg - NFC_W'(1);
                    pend_next = 1'b1;
                end else if (take) begin
                    pend_next = 1'b0;
                end
                if (take && !blen_full) blen_next = blen_reg + BLEN_W'(1);
            end
            ST_END: begin
                pk_ctl.fin  = fin_needed && !pk_sts.busy;
                pk_ctl.cond = cond_reg;
            end
            default: ;
        endcase

        // table add; width grows when the next code no longer fits
        if (do_add && (nfc_reg < NFC_W'(TABLE_SIZE))) begin
            nfc_next = nfc_inc;
            if (((nfc_inc & wmask) == '0) && (nfc_inc < NFC_W'(TABLE_SIZE)))
                width_next = width_reg + CW_W'(1);
        end

        // configuration writes
        if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_CODE_SIZE: begin
                    mcs_next        = cfg_wdata[MCS_W-1:0];
                    buf_next        = '0;
                    bcnt_next       = '0;
                    width_next      = eff_size(cfg_wdata[MCS_W-1:0]) + CW_W'(1);
                    nfc_next        = (NFC_W'(1) << eff_size(cfg_wdata[MCS_W-1:0]))
                                      + NFC_W'(2);
                    prev_next       = '0;
                    prev_valid_next = 1'b0;
                    emitted_next    = '0;
                    finished_next   = 1'b0;
                    failed_next     = 1'b0;
                end
                REG_EXPECTED_PIXELS: expected_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dict_we    = do_add && (nfc_reg < NFC_W'(TABLE_SIZE));
    assign dict_wdata = '{prefix: prev_reg, suffix: add_suffix};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mcs_reg        <= MCS_RESET;
            expected_reg   <= '0;
            buf_reg        <= '0;
            bcnt_reg       <= '0;
            width_reg      <= eff_size(MCS_RESET) + CW_W'(1);
            nfc_reg        <= (NFC_W'(1) << eff_size(MCS_RESET)) + NFC_W'(2);
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            prev_first_reg <= '0;
            cur_reg        <= '0;
            c_reg          <= '0;
            add_pend_reg   <= 1'b0;
            emitted_reg    <= '0;
            finished_reg   <= 1'b0;
            failed_reg     <= 1'b0;
            cond_reg       <= COND_RUN;
            sp_reg         <= '0;
            pend_reg       <= 1'b0;
            blen_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            mcs_reg        <= mcs_next;
            expected_reg   <= expected_next;
            buf_reg        <= buf_next;
            bcnt_reg       <= bcnt_next;
            width_reg      <= width_next;
            nfc_reg        <= nfc_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            prev_first_reg <= prev_first_next;
            cur_reg        <= cur_next;
            c_reg          <= c_next;
            add_pend_reg   <= add_pend_next;
            emitted_reg    <= emitted_next;
            finished_reg   <= finished_next;
            failed_reg     <= failed_next;
            cond_reg       <= cond_next;
            sp_reg         <= sp_next;
            pend_reg       <= pend_next;
            blen_reg       <= blen_next;
        end
    end

    glzw_dict u_dict (
        .aclk  (aclk),
        .we    (dict_we),
        .waddr (nfc_reg[ADDR_W-1:0]),
        .wdata (dict_wdata),
        .re    (dict_re),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    glzw_stack u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (sp_reg[ADDR_W-1:0]),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (sp_next[ADDR_W-1:0]),
        .rdata (stk_rdata)
    );

    glzw_pack #(
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (pk_ctl),
        .sts      (pk_sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_stack_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (sp_reg == '0) && !pend_reg)
        else $error("string stack not empty between bytes");

    a_no_add_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        dict_we |-> (nfc_reg < NFC_W'(TABLE_SIZE)) && (nfc_reg >= clr + NFC_W'(2)))
        else $error("table add outside the free code range");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[518:512] <= PCNT_W'(PIXELS_PER_RESULT)))
        else $error("result pixel count above result size");
`endif

endmodule

// ----- hdl/glzw_dict.sv -----
// ----------------------------------------------------------------------------
// glzw_dict
// String table: prefix code and suffix byte per entry.
// ----------------------------------------------------------------------------
module glzw_dict
    import glzw_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  dict_entry_t       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output dict_entry_t       rdata
);

    dict_entry_t mem [TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/glzw_stack.sv -----
// ----------------------------------------------------------------------------
// glzw_stack
// Reversal stack for one decoded string.
// ----------------------------------------------------------------------------
module glzw_stack
    import glzw_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/glzw_pack.sv -----
// ----------------------------------------------------------------------------
// glzw_pack
// Packs pixels into results and holds each result until it is taken.
// ----------------------------------------------------------------------------
module glzw_pack
    import glzw_pkg::*;
#(
    parameter int PIXELS_PER_RESULT = DEF_PIXELS_PER_RESULT
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  pack_ctl_t          ctl,
    output pack_sts_t          sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);

    localparam logic [PCNT_W-1:0] FULL = PCNT_W'(PIXELS_PER_RESULT);

    logic [MAX_PIXELS*8-1:0] data_reg, data_next;
    logic [PCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    valid_reg, valid_next;
    logic                    last_reg, last_next;
    cond_t                   cond_reg, cond_next;

    always_comb begin
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        cond_next  = cond_reg;
        if (valid_reg) begin
            if (m_tready) begin
                valid_next = 1'b0;
                cnt_next   = '0;
                data_next  = '0;
            end
        end else if (ctl.fin) begin
            valid_next = 1'b1;
            last_next  = 1'b1;
            cond_next  = ctl.cond;
        end else if (ctl.push) begin
            if (cnt_reg < FULL) begin
                data_next[cnt_reg[PIX_IDX_W-1:0]*8 +: 8] = ctl.pixel;
                cnt_next = cnt_reg + PCNT_W'(1);
            end else begin
                // full: send it before taking the next pixel
                valid_next = 1'b1;
                last_next  = 1'b0;
                cond_next  = COND_RUN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            cond_reg  <= COND_RUN;
        end else begin
            data_reg  <= data_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            cond_reg  <= cond_next;
        end
    end

    assign sts.ready = !valid_reg && (cnt_reg < FULL);
    assign sts.busy  = valid_reg;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {1'b0, cnt_reg, data_reg};
    assign m_tlast   = last_reg;
    assign m_tuser   = cond_reg;

endmodule
